/* hdl/tct_pkg.sv */
// shared types and constants of the thresholded centroid tracker
// no dependencies; imported by tct_div and thresholded_centroid_tracker
package tct_pkg;

    // field widths
    localparam int PIX_W     = 8;
    localparam int COORD_W   = 8;
    localparam int MASS_W    = 24;
    localparam int MOM_W     = 32;

    // configuration port
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_THR_W   = 8;
    localparam int CFG_ROI_W   = 9;
    localparam int CFG_TGT_W   = 8;
    localparam int CFG_RAD_W   = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROI_SIZE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TARGET_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TARGET_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_RADIUS    = 3'd4;

    // register reset values
    localparam logic [CFG_THR_W-1:0] RST_THRESHOLD = 8'd128;
    localparam logic [CFG_ROI_W-1:0] RST_ROI_SIZE  = 9'd64;
    localparam logic [CFG_TGT_W-1:0] RST_TARGET_X  = 8'd32;
    localparam logic [CFG_TGT_W-1:0] RST_TARGET_Y  = 8'd32;
    localparam logic [CFG_RAD_W-1:0] RST_RADIUS    = 7'd4;

    // largest reported centroid coordinate
    localparam logic [COORD_W-1:0] COORD_MAX = 8'd255;

    // default region limit
    localparam int ROI_MAX_DEF = 256;

    // divider status back to the sequencer
    typedef struct packed {
        logic               done;
        logic [COORD_W-1:0] quot;
    } t_div_out;

endpackage

/* hdl/thresholded_centroid_tracker.sv */
// top level of the thresholded centroid tracker
// depends on tct_pkg and tct_div
//
// Pixels of a square region arrive in raster order on the slave stream, one
// per transaction, tlast on the last pixel. Pixels inside the pinhole disc
// around (target_x, target_y) and pixels at or below the threshold count as
// zero; the rest add to the mass and to both first moments, all saturating.
// The pinhole test and the moment products are formed bit-serially, so a
// pixel occupies the block for an accept step, DW shift-and-add steps, DW
// being the larger of 8 and clog2(ROI_MAX), and an accumulate step. After the
// last pixel the shared bit-serial divider runs twice, column then row, so a
// frame end adds a frame step, two divisions and an emit step before the result
// is registered (only the frame and emit steps when the mass is zero).
// The result waits in an output register and the next frame may start while
// it is not yet taken. Configuration writes are always accepted and must be
// made only while the block is idle.
module thresholded_centroid_tracker
    import tct_pkg::*;
#(
    parameter int ROI_MAX = ROI_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // pixel stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [PIX_W-1:0]      i_s_tdata,   // [7:0] pixel
    input  logic                  i_s_tlast,   // frame_end
    // centroid stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [39:0]           o_m_tdata,   // [7:0] centroid_x, [15:8] centroid_y,
                                               // [39:16] mass
    output logic                  o_m_tuser,   // [0] found
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW    = $clog2(ROI_MAX);               // position counters
    localparam int SW    = CW + 1;                        // region size
    localparam int CMPW  = (SW > CFG_ROI_W) ? SW : CFG_ROI_W;
    localparam int DW    = (CW > PIX_W) ? CW : PIX_W;     // distances, serial steps
    localparam int SQW   = 2 * DW;
    localparam int DSW   = 2 * DW + 1;                    // sum of two squares
    localparam int RRW   = 2 * CFG_RAD_W;
    localparam int PW    = PIX_W + CW;                    // pixel times position
    localparam int STEPW = $clog2(DW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_FRAME,
        S_DIVX,
        S_DIVY,
        S_EMIT
    } t_state;

    // control and state
    t_state              r_state;
    logic [STEPW-1:0]    r_step;
    logic [CW-1:0]       r_col;
    logic [CW-1:0]       r_row;
    logic [MASS_W-1:0]   r_mass;
    logic [MOM_W-1:0]    r_col_mom;
    logic [MOM_W-1:0]    r_row_mom;
    logic [COORD_W-1:0]  r_cx;
    logic [COORD_W-1:0]  r_cy;
    logic                r_found;
    logic                r_out_valid;
    logic [39:0]         r_out_data;
    logic                r_out_user;

    // configuration
    logic [CFG_THR_W-1:0] r_threshold;
    logic [CFG_ROI_W-1:0] r_roi_size;
    logic [CFG_TGT_W-1:0] r_target_x;
    logic [CFG_TGT_W-1:0] r_target_y;
    logic [CFG_RAD_W-1:0] r_radius;

    // serial datapath
    logic [PIX_W-1:0]    r_pix;
    logic                r_last;
    logic [DW-1:0]       r_dx_mp;
    logic [SQW-1:0]      r_dx_mc;
    logic [DW-1:0]       r_dy_mp;
    logic [SQW-1:0]      r_dy_mc;
    logic [DSW-1:0]      r_dist;
    logic [CFG_RAD_W-1:0] r_rad_mp;
    logic [RRW-1:0]      r_rad_mc;
    logic [RRW-1:0]      r_rr;
    logic [PIX_W-1:0]    r_pix_mp;
    logic [PW-1:0]       r_col_mc;
    logic [PW-1:0]       r_row_mc;
    logic [PW-1:0]       r_pcol;
    logic [PW-1:0]       r_prow;

    logic                w_s_acc;
    logic                w_cfg_acc;
    logic [CMPW-1:0]     w_roi_ext;
    logic [CMPW-1:0]     w_size_full;
    logic [SW-1:0]       w_size;
    logic [SW-1:0]       w_col_nx;
    logic [SW-1:0]       w_row_nx;
    logic [DW-1:0]       w_col_e;
    logic [DW-1:0]       w_row_e;
    logic [DW-1:0]       w_tx_e;
    logic [DW-1:0]       w_ty_e;
    logic [DW-1:0]       w_dx;
    logic [DW-1:0]       w_dy;
    logic                w_zero;
    logic [MASS_W:0]     w_mass_sum;
    logic [MOM_W:0]      w_col_sum;
    logic [MOM_W:0]      w_row_sum;
    logic [MASS_W-1:0]   n_mass;
    logic [MOM_W-1:0]    n_col_mom;
    logic [MOM_W-1:0]    n_row_mom;
    logic                w_emit;
    logic                w_div_start;
    logic [MOM_W-1:0]    w_div_num;
    t_div_out            w_div;

    assign w_s_acc   = i_s_tvalid && o_s_tready;
    assign w_cfg_acc = i_cfg_valid && o_cfg_ready;

    // region size: zero acts as one, clamp at ROI_MAX
    always_comb begin
        w_roi_ext = CMPW'(r_roi_size);
        if (w_roi_ext == '0) begin
            w_size_full = CMPW'(1);
        end else if (w_roi_ext > CMPW'(ROI_MAX)) begin
            w_size_full = CMPW'(ROI_MAX);
        end else begin
            w_size_full = w_roi_ext;
        end
        w_size   = w_size_full[SW-1:0];
        w_col_nx = SW'(r_col) + 1'b1;
        w_row_nx = SW'(r_row) + 1'b1;
    end

    // distance of the current position to the pinhole center
    always_comb begin
        w_col_e = DW'(r_col);
        w_row_e = DW'(r_row);
        w_tx_e  = DW'(r_target_x);
        w_ty_e  = DW'(r_target_y);
        w_dx    = (w_col_e >= w_tx_e) ? (w_col_e - w_tx_e) : (w_tx_e - w_col_e);
        w_dy    = (w_row_e >= w_ty_e) ? (w_row_e - w_ty_e) : (w_ty_e - w_row_e);
    end

    // masked or at/below threshold counts as zero, then saturating sums
    always_comb begin
        w_zero     = (r_dist <= DSW'(r_rr)) || (r_pix <= r_threshold);
        w_mass_sum = {1'b0, r_mass} + (MASS_W + 1)'(w_zero ? '0 : r_pix);
        w_col_sum  = {1'b0, r_col_mom} + (MOM_W + 1)'(w_zero ? '0 : r_pcol);
        w_row_sum  = {1'b0, r_row_mom} + (MOM_W + 1)'(w_zero ? '0 : r_prow);
        n_mass     = w_mass_sum[MASS_W] ? '1 : w_mass_sum[MASS_W-1:0];
        n_col_mom  = w_col_sum[MOM_W]   ? '1 : w_col_sum[MOM_W-1:0];
        n_row_mom  = w_row_sum[MOM_W]   ? '1 : w_row_sum[MOM_W-1:0];
    end

    // divider is started for the column moment, then for the row moment
    assign w_div_start = ((r_state == S_FRAME) && (r_mass != '0)) ||
                         ((r_state == S_DIVX) && w_div.done);
    assign w_div_num   = (r_state == S_FRAME) ? r_col_mom : r_row_mom;
    assign w_emit      = (r_state == S_EMIT) && (!r_out_valid || i_m_tready);

    tct_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_mass),
        .o_res   (w_div)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_mass      <= '0;
            r_col_mom   <= '0;
            r_row_mom   <= '0;
            r_cx        <= '0;
            r_cy        <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_data  <= '0;
            r_out_user  <= 1'b0;
            r_threshold <= RST_THRESHOLD;
            r_roi_size  <= RST_ROI_SIZE;
            r_target_x  <= RST_TARGET_X;
            r_target_y  <= RST_TARGET_Y;
            r_radius    <= RST_RADIUS;
        end else begin
            if (w_cfg_acc) begin
                unique case (i_cfg_index)
                    CFG_IDX_THRESHOLD: r_threshold <= i_cfg_data[CFG_THR_W-1:0];
                    CFG_IDX_ROI_SIZE:  r_roi_size  <= i_cfg_data[CFG_ROI_W-1:0];
                    CFG_IDX_TARGET_X:  r_target_x  <= i_cfg_data[CFG_TGT_W-1:0];
                    CFG_IDX_TARGET_Y:  r_target_y  <= i_cfg_data[CFG_TGT_W-1:0];
                    CFG_IDX_RADIUS:    r_radius    <= i_cfg_data[CFG_RAD_W-1:0];
                    default: ;
                endcase
            end

            // a result taken now is replaced in the same cycle when one is emitted
            if (r_out_valid && i_m_tready && !w_emit) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_s_acc) begin
                        r_step  <= STEPW'(DW - 1);
                        r_state <= S_MUL;
                        // advance position, wrapping at the region size
                        if (w_col_nx >= w_size) begin
                            r_col <= '0;
                            if (w_row_nx >= w_size) begin
                                r_row <= '0;
                            end else begin
                                r_row <= w_row_nx[CW-1:0];
                            end
                        end else begin
                            r_col <= w_col_nx[CW-1:0];
                        end
                    end
                end
                S_MUL: begin
                    r_step <= r_step - 1'b1;
                    if (r_step == '0) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_mass    <= n_mass;
                    r_col_mom <= n_col_mom;
                    r_row_mom <= n_row_mom;
                    r_state   <= r_last ? S_FRAME : S_IDLE;
                end
                S_FRAME: begin
                    if (r_mass == '0) begin
                        r_cx    <= '0;
                        r_cy    <= '0;
                        r_found <= 1'b0;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_DIVX;
                    end
                end
                S_DIVX: begin
                    if (w_div.done) begin
                        r_cx    <= w_div.quot;
                        r_state <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    if (w_div.done) begin
                        // centroid at the origin is not a measurement
                        if (r_cx == '0 && w_div.quot == '0) begin
                            r_found <= 1'b0;
                        end else begin
                            r_found <= 1'b1;
                        end
                        r_cy    <= w_div.quot;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_emit) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {r_mass, r_cy, r_cx};
                        r_out_user  <= r_found;
                        r_mass      <= '0;
                        r_col_mom   <= '0;
                        r_row_mom   <= '0;
                        r_col       <= '0;
                        r_row       <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // shift-and-add datapath: squares of the distances, radius squared and
    // pixel times column and row, one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_pix    <= i_s_tdata;
            r_last   <= i_s_tlast;
            r_dx_mp  <= w_dx;
            r_dx_mc  <= SQW'(w_dx);
            r_dy_mp  <= w_dy;
            r_dy_mc  <= SQW'(w_dy);
            r_dist   <= '0;
            r_rad_mp <= r_radius;
            r_rad_mc <= RRW'(r_radius);
            r_rr     <= '0;
            r_pix_mp <= i_s_tdata;
            r_col_mc <= PW'(r_col);
            r_row_mc <= PW'(r_row);
            r_pcol   <= '0;
            r_prow   <= '0;
        end else if (r_state == S_MUL) begin
            r_dist   <= r_dist + DSW'(r_dx_mp[0] ? r_dx_mc : '0)
                               + DSW'(r_dy_mp[0] ? r_dy_mc : '0);
            r_rr     <= r_rr + (r_rad_mp[0] ? r_rad_mc : '0);
            r_pcol   <= r_pcol + (r_pix_mp[0] ? r_col_mc : '0);
            r_prow   <= r_prow + (r_pix_mp[0] ? r_row_mc : '0);
            r_dx_mp  <= r_dx_mp >> 1;
            r_dy_mp  <= r_dy_mp >> 1;
            r_rad_mp <= r_rad_mp >> 1;
            r_pix_mp <= r_pix_mp >> 1;
            r_dx_mc  <= r_dx_mc << 1;
            r_dy_mc  <= r_dy_mc << 1;
            r_rad_mc <= r_rad_mc << 1;
            r_col_mc <= r_col_mc << 1;
            r_row_mc <= r_row_mc << 1;
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_m_tuser   = r_out_user;

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> o_m_tvalid)
        else $error("result transaction not presented after emit");

    a_found_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[15:0] != 16'd0))
        else $error("found with centroid at origin");

    a_lost_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata[15:0] == 16'd0))
        else $error("centroid reported without a measurement");

    a_mass_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[39:16] == 24'd0)) |-> !o_m_tuser)
        else $error("found with zero mass");

endmodule

/* hdl/tct_div.sv */
// bit-serial restoring divider, moment over mass, round half to even, saturate
// depends on tct_pkg
module tct_div
    import tct_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MOM_W-1:0]  i_num,
    input  logic [MASS_W-1:0] i_den,
    output t_div_out          o_res
);

    localparam int CNT_W = $clog2(MOM_W);

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_ROUND
    } t_dstate;

    t_dstate             r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_done;
    logic [COORD_W-1:0]  r_quot;
    logic [MOM_W-1:0]    r_work;   // numerator bits out, quotient bits in
    logic [MASS_W-1:0]   r_rem;
    logic [MASS_W-1:0]   r_den;

    logic [MASS_W:0]     w_rem_sh;
    logic                w_ge;
    logic [MASS_W:0]     w_rem_sub;
    logic [MASS_W:0]     w_twice;
    logic                w_inc;
    logic [MOM_W:0]      w_qr;
    logic [COORD_W-1:0]  w_qsat;

    always_comb begin
        w_rem_sh  = {r_rem, r_work[MOM_W-1]};
        w_ge      = (w_rem_sh >= {1'b0, r_den});
        w_rem_sub = w_rem_sh - {1'b0, r_den};
        w_twice   = {r_rem, 1'b0};
        w_inc     = (w_twice > {1'b0, r_den}) ||
                    ((w_twice == {1'b0, r_den}) && r_work[0]);
        w_qr      = {1'b0, r_work} + (MOM_W + 1)'(w_inc);
        if (w_qr > (MOM_W + 1)'(COORD_MAX)) begin
            w_qsat = COORD_MAX;
        end else begin
            w_qsat = w_qr[COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
            r_quot  <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_cnt   <= CNT_W'(MOM_W - 1);
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= D_ROUND;
                    end
                end
                D_ROUND: begin
                    r_quot  <= w_qsat;
                    r_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        if (r_state == D_IDLE && i_start) begin
            r_work <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_state == D_RUN) begin
            r_work <= {r_work[MOM_W-2:0], w_ge};
            r_rem  <= w_ge ? w_rem_sub[MASS_W-1:0] : w_rem_sh[MASS_W-1:0];
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quot;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == D_IDLE))
        else $error("divider started while busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done longer than one cycle");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == D_RUN && r_cnt == '0) |=> (r_state == D_ROUND))
        else $error("divider missed its rounding step");

endmodule
